/* rtl/kvt_pkg.sv */
// Package of the small key/value table: types, codes and constants.
package kvt_pkg;

	localparam int ENTRIES_DEFAULT = 16;

	localparam int KEY_W   = 8;
	localparam int VALUE_W = 32;
	localparam int CMD_W   = 2;

	typedef logic [KEY_W-1:0]          key_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [CMD_W-1:0]          cmd_t;

	localparam cmd_t CMD_SET   = 2'd0;
	localparam cmd_t CMD_GET   = 2'd1;
	localparam cmd_t CMD_ERASE = 2'd2;

	localparam key_t   EMPTY_KEY = 8'd42;
	localparam value_t NO_VALUE  = -32'sd1;

	typedef struct packed {
		key_t   key;
		value_t value;
	} entry_t;

	typedef struct packed {
		logic   wr_key;
		logic   wr_value;
		key_t   key;
		value_t value;
	} edit_t;

	typedef struct packed {
		logic match;
		logic empty;
	} flags_t;

endpackage

/* rtl/kvt_req_if.sv */
// Request channel of the small key/value table.
interface kvt_req_if;

	logic                  valid;
	logic                  ready;
	kvt_pkg::cmd_t         cmd;
	kvt_pkg::key_t         key;
	kvt_pkg::value_t       value;

	modport source (output valid, output cmd, output key, output value, input ready);
	modport sink   (input valid, input cmd, input key, input value, output ready);

endinterface

/* rtl/kvt_rsp_if.sv */
// Response channel of the small key/value table.
interface kvt_rsp_if;

	logic                  valid;
	logic                  ready;
	kvt_pkg::value_t       read_value;
	logic                  found;
	logic                  table_full;

	modport source (output valid, output read_value, output found, output table_full,
		input ready);
	modport sink   (input valid, input read_value, input found, input table_full,
		output ready);

endinterface

/* rtl/kvt_cell.sv */
// One cell of the entry ring: holds an entry, compares its key and passes it on, edited.
module kvt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  kvt_pkg::entry_t up,
	input  kvt_pkg::edit_t  edit,
	input  kvt_pkg::key_t   req_key,
	output kvt_pkg::entry_t pass,
	output kvt_pkg::flags_t flags
);

	kvt_pkg::entry_t held_q;

	always_comb begin
		pass = held_q;
		if (edit.wr_key) begin
			pass.key = edit.key;
		end
		if (edit.wr_value) begin
			pass.value = edit.value;
		end
	end

	assign flags.match = (held_q.key == req_key);
	assign flags.empty = (held_q.key == kvt_pkg::EMPTY_KEY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q.key   <= kvt_pkg::EMPTY_KEY;
			held_q.value <= kvt_pkg::NO_VALUE;
		end else if (shift) begin
			held_q <= up;
		end
	end

endmodule

/* rtl/kvt_ctrl.sv */
// Sequencer of the key/value table: steps the ring, decides edits and builds the response.
module kvt_ctrl #(
	parameter int ENTRIES = kvt_pkg::ENTRIES_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	kvt_req_if.sink         req,
	kvt_rsp_if.source       rsp,
	input  kvt_pkg::entry_t head,
	input  kvt_pkg::flags_t head_flags,
	output kvt_pkg::edit_t  edit,
	output logic            shift,
	output kvt_pkg::key_t   req_key
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_FILL = 4'b0100,
		ST_PUSH = 4'b1000
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  last_q;
	kvt_pkg::cmd_t     cmd_q;
	kvt_pkg::key_t     key_q;
	kvt_pkg::value_t   value_q;
	logic              found_q;
	logic              empty_q;
	logic              full_q;
	kvt_pkg::value_t   rd_q;
	logic              out_valid_q;
	kvt_pkg::value_t   out_rd_q;
	logic              out_found_q;
	logic              out_full_q;
	logic              cmd_known;
	logic              hit;

	assign cmd_known = cmd_q inside {kvt_pkg::CMD_SET, kvt_pkg::CMD_GET, kvt_pkg::CMD_ERASE};
	assign hit       = cmd_known && head_flags.match;

	assign req.ready      = (state_q == ST_IDLE);
	assign shift          = (state_q == ST_SCAN) || (state_q == ST_FILL);
	assign req_key        = key_q;
	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_rd_q;
	assign rsp.found      = out_found_q;
	assign rsp.table_full = out_full_q;

	always_comb begin
		edit = '0;
		case (state_q)
			ST_SCAN: begin
				if (cmd_q == kvt_pkg::CMD_SET && head_flags.match && !found_q) begin
					edit.wr_value = 1'b1;
					edit.value    = value_q;
				end
				if (cmd_q == kvt_pkg::CMD_ERASE && head_flags.match) begin
					edit.wr_key = 1'b1;
					edit.key    = kvt_pkg::EMPTY_KEY;
				end
			end
			ST_FILL: begin
				if (cnt_q == last_q) begin
					edit.wr_key   = 1'b1;
					edit.wr_value = 1'b1;
					edit.key      = key_q;
					edit.value    = value_q;
				end
			end
			default: begin
				edit = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					cmd_q   <= req.cmd;
					key_q   <= req.key;
					value_q <= req.value;
					rd_q    <= kvt_pkg::NO_VALUE;
				end
			end
			ST_SCAN: begin
				if (hit && !found_q && cmd_q == kvt_pkg::CMD_GET) begin
					rd_q <= head.value;
				end
				if (head_flags.empty) begin
					last_q <= cnt_q;
				end
			end
			ST_PUSH: begin
				if (!out_valid_q || rsp.ready) begin
					out_rd_q    <= rd_q;
					out_found_q <= found_q;
					out_full_q  <= full_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			empty_q     <= 1'b0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_PUSH && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						empty_q <= 1'b0;
						full_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (head_flags.empty) begin
						empty_q <= 1'b1;
					end
					if (cnt_q == LAST_IDX) begin
						cnt_q <= '0;
						if (cmd_q == kvt_pkg::CMD_SET && !(found_q || hit)) begin
							if (empty_q || head_flags.empty) begin
								state_q <= ST_FILL;
							end else begin
								full_q  <= 1'b1;
								state_q <= ST_PUSH;
							end
						end else begin
							state_q <= ST_PUSH;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FILL: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= ST_PUSH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PUSH: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/small_key_value_table.sv */
// Top level of the small key/value table: a ring of entry cells and its sequencer.
//
// The table holds ENTRIES entries, each an 8-bit key and a signed 32-bit value, in a ring
// of cells that rotates by one place per cycle, while a request is scanned or filled, past
// a single compare and edit point. A request is one transaction on req and gives exactly
// one transaction on rsp. A get, an erase, a set that updates an existing key and any
// unused command take one full turn of the ring; a set that inserts into an empty entry
// takes a second full turn, since one is needed to reach the highest empty entry, and a set
// on a full table is dropped and reported by table_full. A response waiting in the output
// register holds the next request only at its end, until the response is taken. After
// reset all keys read as empty (42) and all values as -1, with no clearing pass.
module small_key_value_table #(
	parameter int ENTRIES = kvt_pkg::ENTRIES_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	kvt_req_if.sink   req,
	kvt_rsp_if.source rsp
);

	kvt_pkg::entry_t pass [ENTRIES];
	kvt_pkg::edit_t  head_edit;
	kvt_pkg::flags_t head_flags;
	kvt_pkg::key_t   req_key;
	logic            shift;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		localparam int NXT = (i + 1) % ENTRIES;
		if (i == 0) begin : g_head
			kvt_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.up      (pass[NXT]),
				.edit    (head_edit),
				.req_key (req_key),
				.pass    (pass[i]),
				.flags   (head_flags)
			);
		end else begin : g_body
			kvt_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.up      (pass[NXT]),
				.edit    ('0),
				.req_key (req_key),
				.pass    (pass[i]),
				.flags   ()
			);
		end
	end

	kvt_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.head       (pass[0]),
		.head_flags (head_flags),
		.edit       (head_edit),
		.shift      (shift),
		.req_key    (req_key)
	);

endmodule

/* verif/tb_top.sv */
// Self-checking testbench of the small key/value table: scoreboard, request driver and checks.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int            ENTRIES     = 16;
	localparam kvt_pkg::cmd_t CMD_UNUSED  = 2'd3;
	localparam int            KEY_POOL    = 24;
	localparam int            PHASE_ITEMS = 385;
	localparam int            CYCLE_LIMIT = 1000000;
	localparam int            REPORT_MAX  = 10;

	typedef struct packed {
		kvt_pkg::value_t read_value;
		logic            found;
		logic            table_full;
	} reply_t;

	class table_scoreboard;
		kvt_pkg::key_t   keys [ENTRIES];
		kvt_pkg::value_t values [ENTRIES];
		reply_t          awaited [$];
		int              mismatches;
		int              checked;
		int              sets;
		int              gets;
		int              erases;
		int              unused;
		int              drops;
		int              hits;

		function new();
			int i;
			for (i = 0; i < ENTRIES; i++) begin
				keys[i] = kvt_pkg::EMPTY_KEY;
				values[i] = kvt_pkg::NO_VALUE;
			end
		endfunction

		function void note_request(kvt_pkg::cmd_t c, kvt_pkg::key_t k, kvt_pkg::value_t v);
			reply_t r;
			int     hit;
			int     spare;
			int     i;
			hit = -1;
			spare = -1;
			for (i = 0; i < ENTRIES; i++) begin
				if (keys[i] == k && hit < 0)
					hit = i;
				if (keys[i] == kvt_pkg::EMPTY_KEY)
					spare = i;
			end
			r.read_value = kvt_pkg::NO_VALUE;
			r.found = (hit >= 0);
			r.table_full = 1'b0;
			case (c)
				kvt_pkg::CMD_SET: begin
					sets++;
					if (hit >= 0) begin
						values[hit] = v;
					end else if (spare >= 0) begin
						keys[spare] = k;
						values[spare] = v;
					end else begin
						r.table_full = 1'b1;
						drops++;
					end
				end
				kvt_pkg::CMD_GET: begin
					gets++;
					if (hit >= 0)
						r.read_value = values[hit];
				end
				kvt_pkg::CMD_ERASE: begin
					erases++;
					for (i = 0; i < ENTRIES; i++)
						if (keys[i] == k)
							keys[i] = kvt_pkg::EMPTY_KEY;
				end
				default: begin
					unused++;
					r.found = 1'b0;
				end
			endcase
			if (r.found)
				hits++;
			awaited.push_back(r);
		endfunction

		function void check_reply(kvt_pkg::value_t rv, logic f, logic full);
			reply_t want;
			checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: unexpected response read_value=%0d found=%0b table_full=%0b",
						$realtime, rv, f, full);
				return;
			end
			want = awaited.pop_front();
			if (rv !== want.read_value || f !== want.found || full !== want.table_full) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display({"%0t: response %0d: read_value %0d/%0d found %0b/%0b ",
						"table_full %0b/%0b (expected/actual)"},
						$realtime, checked, want.read_value, rv, want.found, f,
						want.table_full, full);
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	int            send_idle_pct;
	int            recv_stall_pct;
	kvt_pkg::key_t key_pool [KEY_POOL];

	table_scoreboard board;

	kvt_req_if req ();
	kvt_rsp_if rsp ();

	small_key_value_table #(.ENTRIES(ENTRIES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[small_key_value_table] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				board.note_request(req.cmd, req.key, req.value);
			if (rsp.valid && rsp.ready)
				board.check_reply(rsp.read_value, rsp.found, rsp.table_full);
		end
	end

	always @(negedge clk)
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send_request(kvt_pkg::cmd_t c, kvt_pkg::key_t k, kvt_pkg::value_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= c;
		req.key <= k;
		req.value <= v;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_all_replies();
		req.valid <= 1'b0;
		@(negedge clk);
		while (board.awaited.size() != 0)
			@(negedge clk);
	endtask

	function automatic kvt_pkg::key_t pick_key();
		if ($urandom_range(99) < 85)
			return key_pool[$urandom_range(KEY_POOL - 1)];
		return kvt_pkg::key_t'($urandom());
	endfunction

	task automatic run_random(int count);
		int            done;
		int            roll;
		int            set_w;
		int            erase_w;
		kvt_pkg::cmd_t c;
		kvt_pkg::key_t k;
		done = 0;
		while (done < count) begin
			if ((done / 48) % 2 == 0) begin
				set_w = 55;
				erase_w = 10;
			end else begin
				set_w = 20;
				erase_w = 40;
			end
			roll = $urandom_range(99);
			if (roll < 3)
				c = CMD_UNUSED;
			else if (roll < 3 + set_w)
				c = kvt_pkg::CMD_SET;
			else if (roll < 3 + set_w + erase_w)
				c = kvt_pkg::CMD_ERASE;
			else
				c = kvt_pkg::CMD_GET;
			k = pick_key();
			send_request(c, k, kvt_pkg::value_t'($urandom()));
			if (c != CMD_UNUSED)
				done++;
			if (c == kvt_pkg::CMD_SET && $urandom_range(3) == 0) begin
				send_request(kvt_pkg::CMD_GET, k, kvt_pkg::value_t'($urandom()));
				done++;
			end
		end
	endtask

	initial begin
		int i;
		board = new();
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		req.valid = 1'b0;
		req.cmd = kvt_pkg::CMD_GET;
		req.key = '0;
		req.value = '0;
		rsp.ready = 1'b0;
		key_pool[0] = 8'd0;
		key_pool[1] = 8'd255;
		key_pool[2] = kvt_pkg::EMPTY_KEY;
		for (i = 3; i < KEY_POOL; i++)
			key_pool[i] = kvt_pkg::key_t'($urandom());
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(kvt_pkg::CMD_SET, 8'd0, 32'sh7fffffff);
		send_request(kvt_pkg::CMD_SET, 8'd255, 32'sh80000000);
		send_request(kvt_pkg::CMD_GET, 8'd0, '0);
		send_request(kvt_pkg::CMD_GET, 8'd255, '1);
		send_request(kvt_pkg::CMD_SET, kvt_pkg::EMPTY_KEY, 32'sd5);
		send_request(kvt_pkg::CMD_GET, kvt_pkg::EMPTY_KEY, '0);
		send_request(kvt_pkg::CMD_ERASE, kvt_pkg::EMPTY_KEY, '0);
		send_request(CMD_UNUSED, 8'd0, '1);
		for (i = 1; i <= 14; i++)
			send_request(kvt_pkg::CMD_SET, kvt_pkg::key_t'(i), kvt_pkg::value_t'($urandom()));
		send_request(kvt_pkg::CMD_SET, 8'd100, 32'sd100);
		send_request(kvt_pkg::CMD_GET, 8'd100, '0);
		send_request(kvt_pkg::CMD_ERASE, 8'd0, '0);
		send_request(kvt_pkg::CMD_GET, 8'd0, '0);
		wait_all_replies();

		run_random(PHASE_ITEMS);
		wait_all_replies();
		send_idle_pct = 79;
		run_random(PHASE_ITEMS);
		wait_all_replies();
		send_idle_pct = 0;
		recv_stall_pct = 79;
		run_random(PHASE_ITEMS);
		wait_all_replies();
		send_idle_pct = 29;
		recv_stall_pct = 29;
		run_random(PHASE_ITEMS);
		wait_all_replies();
		recv_stall_pct = 0;
		repeat (2 * ENTRIES + 8) @(negedge clk);

		$display("Covered %0d sets, %0d gets, %0d erases, %0d unused commands; %0d key hits.",
			board.sets, board.gets, board.erases, board.unused, board.hits);
		$display("%0d sets dropped on a full table; %0d responses checked, %0d mismatches.",
			board.drops, board.checked, board.mismatches);
		if (board.mismatches == 0 && board.awaited.size() == 0) begin
			$display("[small_key_value_table] OK");
		end else begin
			$display("[small_key_value_table] ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/kvt_pkg.sv
rtl/kvt_req_if.sv
rtl/kvt_rsp_if.sv
rtl/kvt_cell.sv
rtl/kvt_ctrl.sv
rtl/small_key_value_table.sv
verif/tb_top.sv
